// ===== hdl/rmt_pkg.sv =====
// Shared types and constants of the reachability miss tracker.
// Used by rmt_csr, rmt_core and reachability_miss_tracker_unit; depends on nothing.
package rmt_pkg;

   localparam int MAX_SLOTS = 4;
   localparam int TIME_W    = 48;
   localparam int MISS_W    = 20;
   localparam int REASON_W  = 8;
   localparam int CSR_AW    = 5;

   localparam logic [MISS_W-1:0] MISS_CEILING = 20'd1000000;

   localparam logic [2:0] REG_STRIKES     = 3'd0;
   localparam logic [2:0] REG_INTERVAL    = 3'd1;
   localparam logic [2:0] REG_SAY_AGAIN   = 3'd2;
   localparam logic [2:0] REG_DELAY_COUNT = 3'd3;
   localparam logic [2:0] REG_DELAY_0     = 3'd4;
   localparam logic [2:0] REG_DELAY_1     = 3'd5;
   localparam logic [2:0] REG_DELAY_2     = 3'd6;
   localparam logic [2:0] REG_DELAY_3     = 3'd7;

   typedef enum logic [1:0] {
      OP_ANSWERED = 2'd0,
      OP_MISSED   = 2'd1,
      OP_FORGET   = 2'd2
   } op_type;

   typedef struct packed {
      op_type                operation;
      logic [TIME_W-1:0]     now_ms;
      logic [REASON_W-1:0]   reason_code;
   } req_type;

   typedef struct packed {
      logic        is_down;
      logic        state_changed;
      logic        announce;
      logic [31:0] wait_ms;
   } rsp_type;

   typedef struct packed {
      logic [15:0]                  strikes;
      logic [31:0]                  interval_ms;
      logic [31:0]                  say_again_ms;
      logic [2:0]                   delay_count;
      logic [MAX_SLOTS-1:0][31:0]   delay_ms;
   } cfg_type;

endpackage

// ===== hdl/rmt_csr.sv =====
// APB-style configuration registers of the reachability miss tracker.
// Depends on rmt_pkg for the register indexes and the configuration struct.
module rmt_csr #(
   parameter int DELAY_SLOTS = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rmt_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output rmt_pkg::cfg_type            cfg
);
   import rmt_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[CSR_AW-1:2];
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.strikes      <= 16'd1;
         cfg_ff.interval_ms  <= 32'd1000;
         cfg_ff.say_again_ms <= 32'd0;
         cfg_ff.delay_count  <= 3'd0;
         cfg_ff.delay_ms     <= '0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_STRIKES:     cfg_ff.strikes      <= pwdata[15:0];
            REG_INTERVAL:    cfg_ff.interval_ms  <= pwdata;
            REG_SAY_AGAIN:   cfg_ff.say_again_ms <= pwdata;
            REG_DELAY_COUNT: cfg_ff.delay_count  <= pwdata[2:0];
            default: begin
               for (int i = 0; i < DELAY_SLOTS; i++) begin
                  if (reg_idx == REG_DELAY_0 + 3'(i)) begin
                     cfg_ff.delay_ms[i] <= pwdata;
                  end
               end
            end
         endcase
      end
   end

   always_comb begin
      prdata = 32'd0;
      case (reg_idx)
         REG_STRIKES:     prdata = {16'd0, cfg_ff.strikes};
         REG_INTERVAL:    prdata = cfg_ff.interval_ms;
         REG_SAY_AGAIN:   prdata = cfg_ff.say_again_ms;
         REG_DELAY_COUNT: prdata = {29'd0, cfg_ff.delay_count};
         default: begin
            for (int i = 0; i < DELAY_SLOTS; i++) begin
               if (reg_idx == REG_DELAY_0 + 3'(i)) begin
                  prdata = cfg_ff.delay_ms[i];
               end
            end
         end
      endcase
   end

endmodule

// ===== hdl/rmt_core.sv =====
// Up/down decision, miss counting and retry wait selection of the tracker.
// Holds the partner state; depends on rmt_pkg for the beat and configuration types.
module rmt_core #(
   parameter int DELAY_SLOTS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  rmt_pkg::cfg_type  cfg,
   input  rmt_pkg::req_type  item,
   input  logic              advance,
   output logic              has_result,
   output rmt_pkg::rsp_type  result
);
   import rmt_pkg::*;

   localparam logic [2:0] SLOTS_3 = 3'(DELAY_SLOTS);

   logic                 down_ff, down_in;
   logic [MISS_W-1:0]    miss_ff, miss_in;
   logic [REASON_W-1:0]  reason_ff, reason_in;
   logic [TIME_W-1:0]    last_ann_ff, last_ann_in;

   logic [15:0]          need;
   logic [MISS_W-1:0]    miss_next;
   logic [MISS_W-1:0]    step_raw;
   logic [2:0]           used;
   logic [2:0]           used_last;
   logic [2:0]           step;
   logic [31:0]          tab_wait;
   logic [31:0]          miss_wait;
   logic [TIME_W-1:0]    elapsed;
   logic                 repeat_due;
   logic                 differ;
   logic                 turn;
   logic                 miss_say;

   assign need      = (cfg.strikes == 16'd0) ? 16'd1 : cfg.strikes;
   assign miss_next = (miss_ff < MISS_CEILING) ? miss_ff + 20'd1 : miss_ff;
   assign step_raw  = miss_next - 20'd1;
   assign used      = (cfg.delay_count > SLOTS_3) ? SLOTS_3 : cfg.delay_count;
   assign used_last = used - 3'd1;
   assign step      = (step_raw > {17'd0, used_last}) ? used_last : step_raw[2:0];

   always_comb begin
      tab_wait = 32'd0;
      for (int i = 0; i < DELAY_SLOTS; i++) begin
         if (step == 3'(i)) begin
            tab_wait = cfg.delay_ms[i];
         end
      end
   end

   assign miss_wait  = (used == 3'd0) ? cfg.interval_ms : tab_wait;
   assign elapsed    = item.now_ms - last_ann_ff;
   assign repeat_due = (cfg.say_again_ms != 32'd0) && (item.now_ms >= last_ann_ff) &&
                       (elapsed >= {16'd0, cfg.say_again_ms});
   assign differ     = (reason_ff != item.reason_code);
   assign turn       = !down_ff && ({4'd0, need} <= miss_next);
   assign miss_say   = turn || ((down_ff || turn) && (differ || repeat_due));

   always_comb begin
      has_result  = 1'b0;
      result      = '0;
      down_in     = down_ff;
      miss_in     = miss_ff;
      reason_in   = reason_ff;
      last_ann_in = last_ann_ff;
      case (item.operation)
         OP_ANSWERED: begin
            has_result           = 1'b1;
            result.is_down       = 1'b0;
            result.state_changed = down_ff;
            result.announce      = down_ff;
            result.wait_ms       = cfg.interval_ms;
            down_in              = 1'b0;
            miss_in              = '0;
            reason_in            = '0;
            if (down_ff) begin
               last_ann_in = item.now_ms;
            end
         end
         OP_MISSED: begin
            has_result           = 1'b1;
            result.is_down       = down_ff || turn;
            result.state_changed = turn;
            result.announce      = miss_say;
            result.wait_ms       = miss_wait;
            down_in              = down_ff || turn;
            miss_in              = miss_next;
            reason_in            = item.reason_code;
            if (miss_say) begin
               last_ann_in = item.now_ms;
            end
         end
         OP_FORGET: begin
            down_in     = 1'b0;
            miss_in     = '0;
            reason_in   = '0;
            last_ann_in = '0;
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         down_ff     <= 1'b0;
         miss_ff     <= '0;
         reason_ff   <= '0;
         last_ann_ff <= '0;
      end else if (advance) begin
         down_ff     <= down_in;
         miss_ff     <= miss_in;
         reason_ff   <= reason_in;
         last_ann_ff <= last_ann_in;
      end
   end

endmodule

// ===== hdl/reachability_miss_tracker_unit.sv =====
// Reachability miss tracker: turns probe outcomes into up/down reports with retry waits.
// Every event beat is registered on entry and decided from that input register, and its
// result beat waits in an output register. One event beat is taken per clock while the
// port does not stall, and the result beat reaches the result port through the input
// register and then the output register. A result beat held by rsp_stall blocks the next
// decision that yields a result, and once the input register is also occupied the event
// port stalls. Forget events and the unused operation code leave no result beat. The
// combinational decision path (miss compare, elapsed-time compare and delay-table select)
// sets this rate.
// Depends on rmt_pkg, rmt_csr and rmt_core.
module reachability_miss_tracker_unit #(
   parameter int DELAY_SLOTS = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  rmt_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output rmt_pkg::rsp_type            rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rmt_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import rmt_pkg::*;

   cfg_type  cfg;
   logic     in_valid_ff;
   req_type  in_item_ff;
   logic     out_valid_ff;
   rsp_type  out_item_ff;
   logic     has_result;
   rsp_type  result;
   logic     advance;

   rmt_csr #(
      .DELAY_SLOTS (DELAY_SLOTS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rmt_core #(
      .DELAY_SLOTS (DELAY_SLOTS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item       (in_item_ff),
      .advance    (advance),
      .has_result (has_result),
      .result     (result)
   );

   assign advance   = in_valid_ff && (!has_result || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && has_result) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         out_item_ff <= result;
      end
   end

endmodule

// ===== sim/reachability_miss_tracker_unit_test.sv =====
// Self-checking testbench for reachability_miss_tracker_unit: a directed table, then random
// phases of probe events under random sender gaps and receiver stalls, checked by a predictor.
// Depends on rmt_pkg and the reachability_miss_tracker_unit RTL.
`timescale 1ns / 100ps

module reachability_miss_tracker_unit_test;
   import rmt_pkg::*;

   localparam op_type OP_UNUSED        = op_type'(2'd3);
   localparam int     PHASE_COUNT      = 16;
   localparam int     EVENTS_PER_PHASE = 125;
   localparam int     DRAIN_CYCLES     = 8;
   localparam int     HOLD_CYCLES      = 300;
   localparam int     TIMEOUT_NS       = 2000000;

   typedef enum logic {ROW_EVENT, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [2:0]   reg_idx;
      logic [31:0]  reg_value;
      req_type      beat;
      bit           typed;
      rsp_type      verdict;
   } script_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   cfg_type            shadow;
   logic               down_now;
   logic [MISS_W-1:0]  miss_run;
   logic [REASON_W-1:0] prior_reason;
   logic [TIME_W-1:0]  said_at_ms;

   rsp_type        pending_reports[$];
   script_row_type script[$];
   int             failures;
   int             burst_left;
   bit             hold_off_req;
   logic [TIME_W-1:0] clock_ms;

   reachability_miss_tracker_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic bit predict_report(input req_type beat, output rsp_type verdict);
      logic [MISS_W-1:0] need;
      int                used;
      int                slot;
      logic [31:0]       wait_ms;
      bit                differ;
      bit                repeat_due;
      bit                turned;
      bit                say;
      verdict = '0;
      need    = (shadow.strikes == 16'd0) ? 20'd1 : {4'd0, shadow.strikes};
      case (beat.operation)
         OP_FORGET: begin
            down_now     = 1'b0;
            miss_run     = '0;
            prior_reason = '0;
            said_at_ms   = '0;
            return 1'b0;
         end
         OP_ANSWERED: begin
            turned       = down_now;
            down_now     = 1'b0;
            miss_run     = '0;
            prior_reason = '0;
            if (turned) said_at_ms = beat.now_ms;
            verdict = '{1'b0, turned, turned, shadow.interval_ms};
            return 1'b1;
         end
         OP_MISSED: begin
            differ       = (prior_reason != beat.reason_code);
            prior_reason = beat.reason_code;
            if (miss_run < MISS_CEILING) miss_run = miss_run + 1'b1;
            used = (shadow.delay_count > MAX_SLOTS) ? MAX_SLOTS : int'(shadow.delay_count);
            if (used == 0) begin
               wait_ms = shadow.interval_ms;
            end else begin
               slot    = (int'(miss_run) >= used) ? used - 1 : int'(miss_run) - 1;
               wait_ms = shadow.delay_ms[slot];
            end
            turned = !down_now && (miss_run >= need);
            if (turned) down_now = 1'b1;
            repeat_due = (shadow.say_again_ms != 32'd0) && (beat.now_ms >= said_at_ms) &&
                         ((beat.now_ms - said_at_ms) >= {16'd0, shadow.say_again_ms});
            say = turned || (down_now && (differ || repeat_due));
            if (say) said_at_ms = beat.now_ms;
            verdict = '{down_now, turned, say, wait_ms};
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic void set_register(input logic [2:0] idx, input logic [31:0] value);
      case (idx)
         REG_STRIKES:     shadow.strikes      = value[15:0];
         REG_INTERVAL:    shadow.interval_ms  = value;
         REG_SAY_AGAIN:   shadow.say_again_ms = value;
         REG_DELAY_COUNT: shadow.delay_count  = value[2:0];
         default:         shadow.delay_ms[idx - REG_DELAY_0] = value;
      endcase
   endfunction

   function automatic req_type make_beat(input op_type op, input logic [TIME_W-1:0] now,
                                         input logic [REASON_W-1:0] reason);
      req_type beat;
      beat.operation   = op;
      beat.now_ms      = now;
      beat.reason_code = reason;
      return beat;
   endfunction

   function automatic void add_event(input op_type op, input logic [TIME_W-1:0] now,
                                     input logic [REASON_W-1:0] reason);
      script_row_type row;
      row       = '{kind: ROW_EVENT, default: '0};
      row.beat  = make_beat(op, now, reason);
      script.push_back(row);
   endfunction

   function automatic void add_checked(input op_type op, input logic [TIME_W-1:0] now,
                                       input logic [REASON_W-1:0] reason, input logic down,
                                       input logic changed, input logic say,
                                       input logic [31:0] wait_ms);
      script_row_type row;
      row         = '{kind: ROW_EVENT, default: '0};
      row.beat    = make_beat(op, now, reason);
      row.typed   = 1'b1;
      row.verdict = '{down, changed, say, wait_ms};
      script.push_back(row);
   endfunction

   function automatic void add_reg(input logic [2:0] idx, input logic [31:0] value);
      script_row_type row;
      row           = '{kind: ROW_REG, default: '0};
      row.reg_idx   = idx;
      row.reg_value = value;
      script.push_back(row);
   endfunction

   function automatic void compare_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         failures++;
      end
   endfunction

   task automatic send_event(input req_type beat, input bit typed, input rsp_type typed_rsp);
      rsp_type verdict;
      int      gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (predict_report(beat, verdict)) pending_reports.push_back(typed ? typed_rsp : verdict);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      set_register(idx, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: result beat with nothing expected, expected none, actual %0h",
                     $time, rsp_data);
            failures++;
         end else begin
            want = pending_reports.pop_front();
            compare_field("is_down", 32'(want.is_down), 32'(rsp_data.is_down));
            compare_field("state_changed", 32'(want.state_changed),
                          32'(rsp_data.state_changed));
            compare_field("announce", 32'(want.announce), 32'(rsp_data.announce));
            compare_field("wait_ms", want.wait_ms, rsp_data.wait_ms);
         end
      end
   end

   initial begin : receiver
      int mode;
      int span;
      mode = 0;
      span = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
         end
         span--;
         case (mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("reachability_miss_tracker_unit verification failed");
      $finish;
   end

   initial begin : stimulus
      logic [31:0]        phase_values [8];
      logic [REASON_W-1:0] reason;
      logic [REASON_W-1:0] run_reason;
      int                 phase;
      int                 phase_events;
      int                 pick;
      int                 roll;
      int                 need;
      int                 run;
      int                 k;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_stall    = 1'b0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      failures     = 0;
      burst_left   = 0;
      hold_off_req = 1'b0;
      clock_ms     = '0;
      shadow       = '0;
      shadow.strikes     = 16'd1;
      shadow.interval_ms = 32'd1000;
      down_now     = 1'b0;
      miss_run     = '0;
      prior_reason = '0;
      said_at_ms   = '0;

      add_checked(OP_ANSWERED, 48'd0, 8'd0, 1'b0, 1'b0, 1'b0, 32'd1000);
      add_checked(OP_MISSED, 48'd10, 8'd5, 1'b1, 1'b1, 1'b1, 32'd1000);
      add_checked(OP_MISSED, 48'd20, 8'd5, 1'b1, 1'b0, 1'b0, 32'd1000);
      add_checked(OP_MISSED, 48'd30, 8'd255, 1'b1, 1'b0, 1'b1, 32'd1000);
      add_event(OP_UNUSED, 48'hFFFF_FFFF_FFFF, 8'd255);
      add_checked(OP_ANSWERED, 48'hFFFF_FFFF_FFFF, 8'd255, 1'b0, 1'b1, 1'b1, 32'd1000);
      add_event(OP_FORGET, 48'd40, 8'd7);
      add_checked(OP_MISSED, 48'd0, 8'd0, 1'b1, 1'b1, 1'b1, 32'd1000);
      add_reg(REG_STRIKES, 32'd0);
      add_reg(REG_INTERVAL, 32'hFFFF_FFFF);
      add_reg(REG_SAY_AGAIN, 32'd100);
      add_reg(REG_DELAY_COUNT, 32'd7);
      add_reg(REG_DELAY_0, 32'd11);
      add_reg(REG_DELAY_1, 32'd22);
      add_reg(REG_DELAY_2, 32'd33);
      add_reg(REG_DELAY_3, 32'hFFFF_FFFF);
      add_event(OP_ANSWERED, 48'd1000, 8'd0);
      add_event(OP_MISSED, 48'd1010, 8'd1);
      add_event(OP_MISSED, 48'd1050, 8'd1);
      add_event(OP_MISSED, 48'd1110, 8'd1);
      add_event(OP_MISSED, 48'd1100, 8'd1);
      add_event(OP_MISSED, 48'd1300, 8'd1);
      add_event(OP_MISSED, 48'd1310, 8'd2);
      add_reg(REG_STRIKES, 32'd3);
      add_reg(REG_DELAY_COUNT, 32'd2);
      add_reg(REG_SAY_AGAIN, 32'hFFFF_FFFF);
      add_event(OP_FORGET, 48'd2000, 8'd0);
      add_event(OP_MISSED, 48'd5, 8'd9);
      add_event(OP_MISSED, 48'd6, 8'd9);
      add_event(OP_MISSED, 48'd7, 8'd9);
      add_event(OP_MISSED, 48'hFFFF_FFFF_FFFF, 8'd9);
      add_event(OP_ANSWERED, 48'hFFFF_FFFF_FFFF, 8'd170);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_REG) begin
            settle();
            write_reg(script[i].reg_idx, script[i].reg_value);
         end else begin
            send_event(script[i].beat, script[i].typed, script[i].verdict);
         end
      end

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         settle();
         if (phase == 0) begin
            foreach (phase_values[j]) phase_values[j] = '0;
            phase_values[REG_STRIKES] = 32'd1;
         end else if (phase == 1) begin
            foreach (phase_values[j]) phase_values[j] = '1;
            phase_values[REG_STRIKES]     = 32'h0000_FFFF;
            phase_values[REG_DELAY_COUNT] = 32'd7;
         end else begin
            phase_values[REG_STRIKES] = ($urandom_range(0, 7) == 0) ?
                                        $urandom_range(0, 65535) : $urandom_range(0, 6);
            phase_values[REG_INTERVAL]  = $urandom;
            phase_values[REG_SAY_AGAIN] = ($urandom_range(0, 5) == 0) ?
                                          $urandom : $urandom_range(0, 60);
            phase_values[REG_DELAY_COUNT] = $urandom_range(0, 7);
            for (k = REG_DELAY_0; k <= REG_DELAY_3; k++) phase_values[k] = $urandom;
         end
         for (k = 0; k < 8; k++) write_reg(3'(k), phase_values[k]);
         if (phase == 3) hold_off_req = 1'b1;

         phase_events = 0;
         while (phase_events < EVENTS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               need       = (shadow.strikes == 16'd0) ? 1 : int'(shadow.strikes);
               run        = $urandom_range(1, (need > 40) ? 40 : need + 3);
               run_reason = 8'($urandom_range(0, 3));
               repeat (run) begin
                  clock_ms = clock_ms + $urandom_range(0, 40);
                  roll     = $urandom_range(0, 9);
                  if (roll < 6)      reason = run_reason;
                  else if (roll < 9) reason = 8'($urandom_range(0, 3));
                  else               reason = 8'($urandom_range(0, 255));
                  send_event(make_beat(OP_MISSED, clock_ms, reason), 1'b0, '0);
               end
               phase_events += run;
               if ($urandom_range(0, 4) != 0) begin
                  clock_ms = clock_ms + $urandom_range(0, 40);
                  send_event(make_beat(OP_ANSWERED, clock_ms, 8'($urandom_range(0, 255))),
                             1'b0, '0);
                  phase_events++;
               end
            end else if (pick < 78) begin
               clock_ms = clock_ms + $urandom_range(0, 40);
               send_event(make_beat(OP_ANSWERED, clock_ms, 8'($urandom_range(0, 255))),
                          1'b0, '0);
               phase_events++;
            end else if (pick < 86) begin
               send_event(make_beat(OP_FORGET, 48'({$urandom, $urandom}),
                                    8'($urandom_range(0, 255))), 1'b0, '0);
               phase_events++;
            end else if (pick < 91) begin
               send_event(make_beat(OP_UNUSED, 48'({$urandom, $urandom}),
                                    8'($urandom_range(0, 255))), 1'b0, '0);
            end else begin
               roll = $urandom_range(0, 3);
               if (roll == 0)      clock_ms = 48'({$urandom, $urandom});
               else if (roll == 1) clock_ms = '0;
               else if (roll == 2) clock_ms = '1;
               else                clock_ms = clock_ms - $urandom_range(1, 100);
               send_event(make_beat(OP_MISSED, clock_ms, 8'($urandom_range(0, 255))),
                          1'b0, '0);
               phase_events++;
            end
         end
      end

      settle();
      if (failures == 0) begin
         $display("reachability_miss_tracker_unit verification clean");
      end else begin
         $display("reachability_miss_tracker_unit verification failed");
      end
      $finish;
   end

endmodule
